[src/conservative_to_primitive_assert.svh]
// Assertion macros for the conservative-to-primitive block.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef CONSERVATIVE_TO_PRIMITIVE_ASSERT_SVH
`define CONSERVATIVE_TO_PRIMITIVE_ASSERT_SVH

// Implication in the same cycle, disabled in reset
`define CTP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctp check failed");

// Implication after a fixed number of cycles, disabled in reset
`define CTP_ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("ctp delayed check failed");

`endif

[src/ctp_pkg.sv]
// Shared widths, lane codes and pipeline types for conservative_to_primitive.
// No dependencies.
package ctp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // divider numerator: magnitude shifted up by the fraction bits
  localparam int NUM_W = DATA_WIDTH + FRAC_BITS;
  // kinetic term after the shift by FRAC_BITS + 1
  localparam int EK_W  = 2 * DATA_WIDTH - FRAC_BITS;
  // internal energy before saturation
  localparam int EP_W  = ((NUM_W > EK_W) ? NUM_W : EK_W) + 2;

  localparam int LANES  = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_E = 2;

  // input register, one stage per quotient bit, then four result stages
  localparam int LATENCY = NUM_W + 5;

  typedef struct packed {
    logic                  last;
    logic [LANES-1:0]      neg;
    logic [DATA_WIDTH-2:0] rho;
  } ctp_side_t;

endpackage

[src/conservative_to_primitive.sv]
// Top level of the conservative-to-primitive converter for 2D Euler cells.
// Depends on ctp_pkg and conservative_to_primitive_assert.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | start / busy         | cons_density momentum_x momentum_y
//           |                      | total_energy last_in
//  result   | done (one cycle)     | prim_density velocity_x velocity_y
//           |                      | internal_energy saturated last_out
//  config   | cfg_valid/cfg_ready  | cfg_data (min_density)
//
// One request per cycle; busy is always low and cfg_ready always high.
// A result passes the input register, the divider stages and stages A to D; the
// depth comes from the restoring divider, one quotient bit per stage (48).
// Synchronous reset clears the valid bits and sets the density floor to 1.
// The receiver cannot stall, so the pipeline never holds.
`include "conservative_to_primitive_assert.svh"

module conservative_to_primitive (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ctp_pkg::DATA_WIDTH-1:0]  cons_density,
  input  logic signed [ctp_pkg::DATA_WIDTH-1:0]  momentum_x,
  input  logic signed [ctp_pkg::DATA_WIDTH-1:0]  momentum_y,
  input  logic signed [ctp_pkg::DATA_WIDTH-1:0]  total_energy,
  input  logic                                   last_in,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [ctp_pkg::DATA_WIDTH-2:0]  cfg_data,
  output logic                                   done,
  output logic        [ctp_pkg::DATA_WIDTH-2:0]  prim_density,
  output logic signed [ctp_pkg::DATA_WIDTH-1:0]  velocity_x,
  output logic signed [ctp_pkg::DATA_WIDTH-1:0]  velocity_y,
  output logic signed [ctp_pkg::DATA_WIDTH-1:0]  internal_energy,
  output logic                                   saturated,
  output logic                                   last_out
);

  localparam int DW  = ctp_pkg::DATA_WIDTH;
  localparam int FB  = ctp_pkg::FRAC_BITS;
  localparam int NW  = ctp_pkg::NUM_W;
  localparam int EKW = ctp_pkg::EK_W;
  localparam int EPW = ctp_pkg::EP_W;

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // density floor register
  logic [DW-2:0] floor_reg;
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_reg <= {{(DW-2){1'b0}}, 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      floor_reg <= cfg_data;
    end
  end

  // clamp density and take magnitudes of the numerators
  logic [DW-2:0] floor_eff;
  logic [DW-2:0] rho_in;
  logic [DW-1:0] mag_x, mag_y, mag_e;
  assign floor_eff = (floor_reg == '0) ? {{(DW-2){1'b0}}, 1'b1} : floor_reg;
  assign rho_in    = (cons_density > $signed({1'b0, floor_eff})) ?
                     cons_density[DW-2:0] : floor_eff;
  assign mag_x = momentum_x[DW-1]   ? (~momentum_x + 1'b1)   : momentum_x;
  assign mag_y = momentum_y[DW-1]   ? (~momentum_y + 1'b1)   : momentum_y;
  assign mag_e = total_energy[DW-1] ? (~total_energy + 1'b1) : total_energy;

  // divider pipeline: numerator shifts out, quotient shifts in
  logic [NW-1:0]      dnum  [0:NW][0:ctp_pkg::LANES-1];
  logic [DW-2:0]      drem  [0:NW][0:ctp_pkg::LANES-1];
  ctp_pkg::ctp_side_t dside [0:NW];
  logic               dvld  [0:NW];

  // input register
  always_ff @(posedge clk) begin
    dnum[0][ctp_pkg::LANE_X] <= {mag_x, {FB{1'b0}}};
    dnum[0][ctp_pkg::LANE_Y] <= {mag_y, {FB{1'b0}}};
    dnum[0][ctp_pkg::LANE_E] <= {mag_e, {FB{1'b0}}};
    drem[0][ctp_pkg::LANE_X] <= '0;
    drem[0][ctp_pkg::LANE_Y] <= '0;
    drem[0][ctp_pkg::LANE_E] <= '0;
    dside[0].last <= last_in;
    dside[0].neg  <= {total_energy[DW-1], momentum_y[DW-1], momentum_x[DW-1]};
    dside[0].rho  <= rho_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else begin
      dvld[0] <= start && !busy;
    end
  end

  // one quotient bit per stage, three lanes in parallel
  for (genvar s = 0; s < NW; s++) begin : g_div
    for (genvar l = 0; l < ctp_pkg::LANES; l++) begin : g_lane
      logic [DW-1:0] r2;
      logic [DW-1:0] diff;
      logic          ge;
      assign r2   = {drem[s][l], dnum[s][l][NW-1]};
      assign diff = r2 - {1'b0, dside[s].rho};
      assign ge   = (r2 >= {1'b0, dside[s].rho});
      always_ff @(posedge clk) begin
        drem[s+1][l] <= ge ? diff[DW-2:0] : r2[DW-2:0];
        dnum[s+1][l] <= {dnum[s][l][NW-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      dside[s+1] <= dside[s];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[s+1] <= 1'b0;
      end else begin
        dvld[s+1] <= dvld[s];
      end
    end
  end

  // stage A: apply signs, saturate velocities
  logic signed [NW:0] qs_x, qs_y, qs_e;
  logic               ovf_x, ovf_y;
  assign qs_x = dside[NW].neg[ctp_pkg::LANE_X] ?
                -$signed({1'b0, dnum[NW][ctp_pkg::LANE_X]}) :
                $signed({1'b0, dnum[NW][ctp_pkg::LANE_X]});
  assign qs_y = dside[NW].neg[ctp_pkg::LANE_Y] ?
                -$signed({1'b0, dnum[NW][ctp_pkg::LANE_Y]}) :
                $signed({1'b0, dnum[NW][ctp_pkg::LANE_Y]});
  assign qs_e = dside[NW].neg[ctp_pkg::LANE_E] ?
                -$signed({1'b0, dnum[NW][ctp_pkg::LANE_E]}) :
                $signed({1'b0, dnum[NW][ctp_pkg::LANE_E]});
  assign ovf_x = !((qs_x[NW:DW-1] == '0) || (qs_x[NW:DW-1] == '1));
  assign ovf_y = !((qs_y[NW:DW-1] == '0) || (qs_y[NW:DW-1] == '1));

  logic [DW-1:0]      a_vx, a_vy;
  logic signed [NW:0] a_qe;
  logic               a_flag, a_vld, a_last;
  logic [DW-2:0]      a_rho;
  always_ff @(posedge clk) begin
    a_vx   <= ovf_x ? (qs_x[NW] ? SMIN : SMAX) : qs_x[DW-1:0];
    a_vy   <= ovf_y ? (qs_y[NW] ? SMIN : SMAX) : qs_y[DW-1:0];
    a_qe   <= qs_e;
    a_flag <= ovf_x || ovf_y;
    a_last <= dside[NW].last;
    a_rho  <= dside[NW].rho;
  end

  // stage B: square the velocity magnitudes
  logic [DW-1:0]   ax, ay;
  logic [2*DW-1:0] b_sqx, b_sqy;
  logic [DW-1:0]   b_vx, b_vy;
  logic signed [NW:0] b_qe;
  logic            b_flag, b_vld, b_last;
  logic [DW-2:0]   b_rho;
  assign ax = a_vx[DW-1] ? (~a_vx + 1'b1) : a_vx;
  assign ay = a_vy[DW-1] ? (~a_vy + 1'b1) : a_vy;
  always_ff @(posedge clk) begin
    b_sqx  <= {{DW{1'b0}}, ax} * {{DW{1'b0}}, ax};
    b_sqy  <= {{DW{1'b0}}, ay} * {{DW{1'b0}}, ay};
    b_vx   <= a_vx;
    b_vy   <= a_vy;
    b_qe   <= a_qe;
    b_flag <= a_flag;
    b_last <= a_last;
    b_rho  <= a_rho;
  end

  // stage C: kinetic term, halved
  logic [2*DW:0]   ksum;
  logic [EKW-1:0]  c_ek;
  logic [DW-1:0]   c_vx, c_vy;
  logic signed [NW:0] c_qe;
  logic            c_flag, c_vld, c_last;
  logic [DW-2:0]   c_rho;
  assign ksum = {1'b0, b_sqx} + {1'b0, b_sqy};
  always_ff @(posedge clk) begin
    c_ek   <= ksum[2*DW:FB+1];
    c_vx   <= b_vx;
    c_vy   <= b_vy;
    c_qe   <= b_qe;
    c_flag <= b_flag;
    c_last <= b_last;
    c_rho  <= b_rho;
  end

  // stage D: subtract, saturate, drive the result
  logic [EPW-1:0] ep;
  logic           ovf_e;
  assign ep    = {{(EPW-NW-1){c_qe[NW]}}, c_qe} - {{(EPW-EKW){1'b0}}, c_ek};
  assign ovf_e = !((ep[EPW-1:DW-1] == '0) || (ep[EPW-1:DW-1] == '1));

  always_ff @(posedge clk) begin
    prim_density    <= c_rho;
    velocity_x      <= c_vx;
    velocity_y      <= c_vy;
    internal_energy <= ovf_e ? (ep[EPW-1] ? SMIN : SMAX) : ep[DW-1:0];
    saturated       <= c_flag || ovf_e;
    last_out        <= c_last;
  end

  // advance the result valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      a_vld <= dvld[NW];
      b_vld <= a_vld;
      c_vld <= b_vld;
      done  <= c_vld;
    end
  end

  `CTP_ASSERT_IMPL(a_density_pos, clk, rst, done, prim_density != '0)
  `CTP_ASSERT_DELAY(a_latency, clk, rst, start && !busy, ctp_pkg::LATENCY, done)
  `CTP_ASSERT_IMPL(a_no_spurious, clk, rst, !$past(start, ctp_pkg::LATENCY) && !$past(rst, ctp_pkg::LATENCY), !done)

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for conservative_to_primitive: directed cells, then
// random cells under several density floors. Depends on ctp_pkg and the RTL.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = ctp_pkg::LATENCY + 8;

  typedef logic signed [ctp_pkg::DATA_WIDTH-1:0] word_t;
  typedef logic [ctp_pkg::DATA_WIDTH-2:0] floor_t;

  typedef struct {
    word_t rho_c;
    word_t mom_x;
    word_t mom_y;
    word_t energy;
    logic  last;
  } cell_t;

  typedef struct {
    floor_t rho_p;
    word_t  vel_x;
    word_t  vel_y;
    word_t  e_int;
    logic   clip;
    logic   last;
  } prim_t;

  typedef struct {
    cell_t req;
    bit    typed;
    prim_t prim;
  } row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  word_t  cons_density = '0;
  word_t  momentum_x = '0;
  word_t  momentum_y = '0;
  word_t  total_energy = '0;
  logic   last_in = 1'b0;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  floor_t cfg_data = '0;
  logic   done;
  floor_t prim_density;
  word_t  velocity_x;
  word_t  velocity_y;
  word_t  internal_energy;
  logic   saturated;
  logic   last_out;

  conservative_to_primitive dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cons_density(cons_density), .momentum_x(momentum_x),
    .momentum_y(momentum_y), .total_energy(total_energy), .last_in(last_in),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .prim_density(prim_density), .velocity_x(velocity_x),
    .velocity_y(velocity_y), .internal_energy(internal_energy),
    .saturated(saturated), .last_out(last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  floor_t floor_q;
  prim_t  pending_prims[$];
  int     errors = 0;
  int     cycles = 0;
  int     cells_sent = 0;
  int     prims_seen = 0;
  int     floors_used = 0;
  int     gap_left = 0;
  int     burst_left = 0;

  // Quotient (num << FRAC_BITS) / den, truncated toward zero
  function automatic longint fx_quot(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag << ctp_pkg::FRAC_BITS) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Clip to the signed data range, raising the flag
  function automatic longint clip_word(longint v, inout logic flag);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ctp_pkg::DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Convert one conserved cell to primitive form under the current floor
  function automatic prim_t to_primitive(cell_t c, floor_t fl_reg);
    prim_t p;
    longint fl;
    longint rho;
    longint vx;
    longint vy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned ek;
    logic flag;
    flag = 1'b0;
    fl = (fl_reg == 0) ? 1 : longint'(fl_reg);
    rho = (longint'(c.rho_c) > fl) ? longint'(c.rho_c) : fl;
    vx = clip_word(fx_quot(longint'(c.mom_x), rho), flag);
    vy = clip_word(fx_quot(longint'(c.mom_y), rho), flag);
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    ek = (ax * ax + ay * ay) >> (ctp_pkg::FRAC_BITS + 1);
    p.e_int = word_t'(clip_word(fx_quot(longint'(c.energy), rho) - longint'(ek), flag));
    p.rho_p = floor_t'(rho);
    p.vel_x = word_t'(vx);
    p.vel_y = word_t'(vy);
    p.clip  = flag;
    p.last  = c.last;
    return p;
  endfunction

  // Drive one request and hold it until accepted
  task automatic send_cell(cell_t c, prim_t p);
    start <= 1'b1;
    cons_density <= c.rho_c;
    momentum_x <= c.mom_x;
    momentum_y <= c.mom_y;
    total_energy <= c.energy;
    last_in <= c.last;
    do @(posedge clk); while (busy);
    pending_prims.push_back(p);
    cells_sent++;
  endtask

  // Insert a random gap between bursts of requests
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_left > 0) begin
        start <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Wait for the pipeline to empty
  task automatic drain();
    start <= 1'b0;
    while (pending_prims.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the density floor while idle
  task automatic write_floor(floor_t v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    floor_q = v;
    floors_used++;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 32'h0008_0000));
      2: return -word_t'($urandom_range(0, 32'h0008_0000));
      3: return word_t'($urandom_range(0, 32'h0100_0000));
      4: return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return word_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.rho_c = ($urandom_range(0, 3) == 0) ? rand_word()
                                          : word_t'($urandom_range(1, 32'h0040_0000));
    c.mom_x = rand_word();
    c.mom_y = rand_word();
    c.energy = rand_word();
    c.last = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    prim_t e;
    if (!rst && done) begin
      prims_seen++;
      if (pending_prims.size() == 0) begin
        $display("%0t: result with no request waiting", $time);
        errors++;
      end else begin
        e = pending_prims.pop_front();
        if (prim_density !== e.rho_p) begin
          $display("%0t: prim_density exp %h got %h", $time, e.rho_p, prim_density);
          errors++;
        end
        if (velocity_x !== e.vel_x) begin
          $display("%0t: velocity_x exp %h got %h", $time, e.vel_x, velocity_x);
          errors++;
        end
        if (velocity_y !== e.vel_y) begin
          $display("%0t: velocity_y exp %h got %h", $time, e.vel_y, velocity_y);
          errors++;
        end
        if (internal_energy !== e.e_int) begin
          $display("%0t: internal_energy exp %h got %h", $time, e.e_int,
                   internal_energy);
          errors++;
        end
        if (saturated !== e.clip) begin
          $display("%0t: saturated exp %b got %b", $time, e.clip, saturated);
          errors++;
        end
        if (last_out !== e.last) begin
          $display("%0t: last_out exp %b got %b", $time, e.last, last_out);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[conservative_to_primitive] ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    floor_t floors[5];
    prim_t p;
    floor_q = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cells under the reset floor; typed results where obvious
    r.typed = 1'b1;
    r.req = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0, 32'sh0002_0000, 1'b0};
    r.prim = '{31'h0001_0000, 32'sh0001_0000, 32'sh0, 32'sh0001_8000, 1'b0, 1'b0};
    rows.push_back(r);
    r.req = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1};
    r.prim = '{31'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b1};
    rows.push_back(r);
    r.req = '{32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0, 1'b0};
    r.prim = '{31'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0};
    rows.push_back(r);
    r.req = '{32'sh7fff_ffff, 32'sh0, 32'sh0, 32'sh0, 1'b1};
    r.prim = '{31'h7fff_ffff, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b1};
    rows.push_back(r);
    r.req = '{32'sh1, 32'sh7fff_ffff, 32'sh0, 32'sh0, 1'b0};
    r.prim = '{31'h1, 32'sh7fff_ffff, 32'sh0, 32'sh8000_0000, 1'b1, 1'b0};
    rows.push_back(r);
    r.typed = 1'b0;
    r.req = '{32'sh1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0};
    rows.push_back(r);
    r.req = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1'b1};
    rows.push_back(r);
    r.req = '{32'shffff_ffff, 32'sh0001_0000, 32'shffff_0000, 32'sh0000_8000, 1'b0};
    rows.push_back(r);
    r.req = '{32'sh0002_0000, -32'sh0003_0000, 32'sh0005_0000, 32'sh0010_0000, 1'b1};
    rows.push_back(r);
    r.req = '{32'sh0000_0100, 32'sh0000_1000, 32'sh0000_2000, -32'sh0000_4000, 1'b0};
    rows.push_back(r);
    r.req = '{32'sh0000_8000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0};
    rows.push_back(r);
    foreach (rows[i]) begin
      p = rows[i].typed ? rows[i].prim : to_primitive(rows[i].req, floor_q);
      send_cell(rows[i].req, p);
    end
    drain();

    // Random cells under floors: zero, one, one unit, maximum, random
    floors[0] = '0;
    floors[1] = 31'h1;
    floors[2] = 31'h0001_0000;
    floors[3] = 31'h7fff_ffff;
    floors[4] = floor_t'($urandom_range(2, 32'h0010_0000));
    foreach (floors[f]) begin
      cell_t c;
      write_floor(floors[f]);
      for (int n = 0; n < 90; n++) begin
        pace_sender();
        c = rand_cell();
        send_cell(c, to_primitive(c, floor_q));
      end
      drain();
    end

    $display("Sent %0d cells, checked %0d results over %0d density floors.",
             cells_sent, prims_seen, floors_used + 1);
    if (errors == 0 && pending_prims.size() == 0) begin
      $display("[conservative_to_primitive] OK");
    end else begin
      $display("[conservative_to_primitive] ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/ctp_pkg.sv
src/conservative_to_primitive.sv
tb/sv/testbench.sv
